/* rtl/anf_lms_pkg.sv */
// Shared types and constants for the adaptive notch filter.
// No dependencies; used by anf_lms_mul and adaptive_notch_filter_lms.
`default_nettype none

package anf_lms_pkg;

   // Shared multiplier operand and product widths
   localparam int MUL_A_W = 22;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef logic signed [MUL_A_W-1:0] mul_a_type;
   typedef logic signed [MUL_B_W-1:0] mul_b_type;
   typedef logic signed [MUL_P_W-1:0] mul_p_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_LAMBDA       = 3'd0;
   localparam logic [2:0] CSR_ONE_MINUS    = 3'd1;
   localparam logic [2:0] CSR_RHO_FINAL    = 3'd2;
   localparam logic [2:0] CSR_STEP_SIZE    = 3'd3;
   localparam logic [2:0] CSR_RHO_START    = 3'd4;

   // Register defaults
   localparam logic [14:0] LAMBDA_RESET    = 15'd29491;
   localparam logic [14:0] ONE_MINUS_RESET = 15'd3276;
   localparam logic [15:0] RHO_FINAL_RESET = 16'd62259;
   localparam logic [14:0] STEP_RESET      = 15'd328;
   localparam logic [15:0] RHO_START_RESET = 16'd32768;

   // Arithmetic constants
   localparam int                 HALF_ROUND = 'h4000;
   localparam logic signed [15:0] COEF_MAX   = 16'sh7FFF;
   localparam logic signed [15:0] COEF_MIN   = -16'sh7FFF;
   localparam int                 GRAD_SHIFT = 9;
   localparam int                 ERR_SHIFT  = 4;

endpackage

`default_nettype wire

/* rtl/anf_lms_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on anf_lms_pkg for operand and product types.
`default_nettype none

module anf_lms_mul (
   input  wire                     clock,
   input  anf_lms_pkg::mul_a_type  op_a,
   input  anf_lms_pkg::mul_b_type  op_b,
   output anf_lms_pkg::mul_p_type  product
);

   anf_lms_pkg::mul_p_type product_ff;
   anf_lms_pkg::mul_p_type product_in;

   assign product_in = anf_lms_pkg::MUL_P_W'(op_a) * anf_lms_pkg::MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

/* rtl/adaptive_notch_filter_lms.sv */
// Top level of the second-order adaptive notch filter with LMS adaptation.
// Depends on anf_lms_pkg and anf_lms_mul.
//
// Usage:
//   req_*  : one signed 16-bit sample per beat (valid/ready).
//   rsp_*  : one signed 21-bit notch error per beat (valid/ready).
//   csr_*  : register writes (index, data); always ready, write only while idle.
// Each sample runs through one shared 22x17 signed multiplier under an
// eleven-step sequencer: nine multiplies for the radius update, the state
// recursion, the error and the coefficient gradient, plus two steps that
// form the error and commit the new state. The error is registered onto
// rsp_* in the commit step, and the block takes no new sample until the
// current one is committed. req_ready is low while a sample is in flight.
// The result sits in an output register; if the receiver stalls, the
// sequencer holds at the gain step until the previous error beat is taken,
// which stretches the sample by the length of the stall.
// Synchronous reset restores the register defaults, loads the pole radius
// with its start value and clears the coefficient and both past states.
`default_nettype none

module adaptive_notch_filter_lms (
   input  wire                clock,
   input  wire                reset,
   // sample channel
   input  wire                req_valid,
   output logic               req_ready,
   input  wire signed [15:0]  req_sample_in,
   // error channel
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic signed [20:0] rsp_error_out,
   // register write channel
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [2:0]         csr_index,
   input  wire  [15:0]        csr_data
);

   // Sequencer steps; all but the error and commit steps issue one multiply
   localparam logic [3:0] STEP_RHO_DECAY  = 4'd0;  // lambda * rho
   localparam logic [3:0] STEP_RHO_TARGET = 4'd1;  // (1-lambda) * rho_final
   localparam logic [3:0] STEP_COEF_PREV  = 4'd2;  // a * s1
   localparam logic [3:0] STEP_RHO_SQUARE = 4'd3;  // rho * rho
   localparam logic [3:0] STEP_RHO_COEF   = 4'd4;  // rho * a
   localparam logic [3:0] STEP_OLDER      = 4'd5;  // rho^2 * s2
   localparam logic [3:0] STEP_PREV       = 4'd6;  // (rho*a) * s1
   localparam logic [3:0] STEP_ERROR      = 4'd7;  // form s and e
   localparam logic [3:0] STEP_GAIN       = 4'd8;  // mu * e
   localparam logic [3:0] STEP_GRAD       = 4'd9;  // (2*mu*e) * s1
   localparam logic [3:0] STEP_UPDATE     = 4'd10; // commit coefficient and state

   // Control
   logic       busy_ff, busy_in;
   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Configuration
   logic [14:0] lambda_ff, lambda_in;
   logic [14:0] one_minus_ff, one_minus_in;
   logic [15:0] rho_final_ff, rho_final_in;
   logic [14:0] step_size_ff, step_size_in;

   // Filter state
   logic [15:0]        pole_ff, pole_in;
   logic signed [15:0] coef_ff, coef_in;
   logic signed [15:0] prev_ff, prev_in;
   logic signed [15:0] older_ff, older_in;

   // Per-sample working registers
   logic signed [15:0] sample_ff, sample_in;
   logic [15:0]        decay_ff, decay_in;
   logic signed [15:0] partial_ff, partial_in;  // wrap16(s2 + q)
   logic [15:0]        rho_sq_ff, rho_sq_in;
   logic signed [16:0] rho_coef_ff, rho_coef_in;
   logic signed [15:0] older_term_ff, older_term_in;
   logic signed [15:0] state_ff, state_in;
   logic signed [20:0] error_ff, error_in;
   logic signed [20:0] rsp_error_ff, rsp_error_in;

   // Shared multiplier
   anf_lms_pkg::mul_a_type op_a;
   anf_lms_pkg::mul_b_type op_b;
   anf_lms_pkg::mul_p_type product;

   anf_lms_pkg::mul_p_type half_round;
   anf_lms_pkg::mul_p_type neg_round;
   anf_lms_pkg::mul_p_type pos_round;
   logic signed [15:0]     state_new;
   logic signed [16:0]     err_sum;
   logic signed [15:0]     coef_new;
   logic                   finish;

   anf_lms_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   assign req_ready     = ~busy_ff;
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_error_out = rsp_error_ff;

   assign half_round = anf_lms_pkg::MUL_P_W'(anf_lms_pkg::HALF_ROUND);
   assign neg_round  = half_round - product;
   assign pos_round  = product + half_round;

   // s = y + p - t, wrapped; p comes straight off the multiplier
   assign state_new = sample_ff + product[30:15] - older_term_ff;
   assign err_sum   = 17'(partial_ff) + 17'(state_new);

   // a + g, wrapped; only the most negative code falls outside +-COEF_MAX
   always_comb begin
      coef_new = coef_ff + product[anf_lms_pkg::GRAD_SHIFT +: 16];
      if (coef_new < anf_lms_pkg::COEF_MIN) begin
         coef_new = anf_lms_pkg::COEF_MIN;
      end
   end

   // Commit in the last step; the output register is free by then
   assign finish = busy_ff && (step_ff == STEP_UPDATE);

   // Operand select for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (step_ff)
         STEP_RHO_DECAY: begin
            op_a = anf_lms_pkg::MUL_A_W'({1'b0, lambda_ff});
            op_b = anf_lms_pkg::MUL_B_W'({1'b0, pole_ff});
         end
         STEP_RHO_TARGET: begin
            op_a = anf_lms_pkg::MUL_A_W'({1'b0, one_minus_ff});
            op_b = anf_lms_pkg::MUL_B_W'({1'b0, rho_final_ff});
         end
         STEP_COEF_PREV: begin
            op_a = anf_lms_pkg::MUL_A_W'(coef_ff);
            op_b = anf_lms_pkg::MUL_B_W'(prev_ff);
         end
         STEP_RHO_SQUARE: begin
            op_a = anf_lms_pkg::MUL_A_W'({1'b0, pole_ff});
            op_b = anf_lms_pkg::MUL_B_W'({1'b0, pole_ff});
         end
         STEP_RHO_COEF: begin
            op_a = anf_lms_pkg::MUL_A_W'({1'b0, pole_ff});
            op_b = anf_lms_pkg::MUL_B_W'(coef_ff);
         end
         STEP_OLDER: begin
            op_a = anf_lms_pkg::MUL_A_W'({1'b0, rho_sq_ff});
            op_b = anf_lms_pkg::MUL_B_W'(older_ff);
         end
         STEP_PREV: begin
            op_a = anf_lms_pkg::MUL_A_W'(rho_coef_ff);
            op_b = anf_lms_pkg::MUL_B_W'(prev_ff);
         end
         STEP_GAIN: begin
            op_a = anf_lms_pkg::MUL_A_W'(error_ff);
            op_b = anf_lms_pkg::MUL_B_W'({1'b0, step_size_ff});
         end
         STEP_GRAD: begin
            // floor(2*mu*e / 2^15) is the product shifted down by 14
            op_a = product[35:14];
            op_b = anf_lms_pkg::MUL_B_W'(prev_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Next-state logic
   always_comb begin
      busy_in       = busy_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_error_in  = rsp_error_ff;
      lambda_in     = lambda_ff;
      one_minus_in  = one_minus_ff;
      rho_final_in  = rho_final_ff;
      step_size_in  = step_size_ff;
      pole_in       = pole_ff;
      coef_in       = coef_ff;
      prev_in       = prev_ff;
      older_in      = older_ff;
      sample_in     = sample_ff;
      decay_in      = decay_ff;
      partial_in    = partial_ff;
      rho_sq_in     = rho_sq_ff;
      rho_coef_in   = rho_coef_ff;
      older_term_in = older_term_ff;
      state_in      = state_ff;
      error_in      = error_ff;

      // Drop the error beat once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes; the start radius only matters at reset, where it
      // takes its default, so accept and drop that write
      if (csr_valid) begin
         unique case (csr_index)
            anf_lms_pkg::CSR_LAMBDA:    lambda_in    = csr_data[14:0];
            anf_lms_pkg::CSR_ONE_MINUS: one_minus_in = csr_data[14:0];
            anf_lms_pkg::CSR_RHO_FINAL: rho_final_in = csr_data;
            anf_lms_pkg::CSR_STEP_SIZE: step_size_in = csr_data[14:0];
            anf_lms_pkg::CSR_RHO_START: ;
            default: ;
         endcase
      end

      // Retire the product issued in the previous step
      if (busy_ff) begin
         case (step_ff)
            STEP_RHO_TARGET: decay_in      = product[30:15];
            STEP_COEF_PREV:  pole_in       = decay_ff + product[30:15];
            STEP_RHO_SQUARE: partial_in    = older_ff + neg_round[30:15];
            STEP_RHO_COEF:   rho_sq_in     = product[31:16];
            STEP_OLDER:      rho_coef_in   = pos_round[32:16];
            STEP_PREV:       older_term_in = product[31:16];
            STEP_ERROR: begin
               state_in = state_new;
               error_in = 21'(err_sum) <<< anf_lms_pkg::ERR_SHIFT;
            end
            default: ;
         endcase

         // Advance the sequencer; hold the gain step while an earlier error
         // beat still waits, since its operands stay put there
         if (step_ff == STEP_GAIN) begin
            if (~rsp_valid_ff || rsp_ready) begin
               step_in = step_ff + 4'd1;
            end
         end else if (step_ff != STEP_UPDATE) begin
            step_in = step_ff + 4'd1;
         end
      end

      // Commit coefficient and state, present the error
      if (finish) begin
         coef_in      = coef_new;
         older_in     = prev_ff;
         prev_in      = state_ff;
         rsp_valid_in = 1'b1;
         rsp_error_in = error_ff;
         busy_in      = 1'b0;
      end

      // Take a new sample
      if (req_valid && req_ready) begin
         sample_in = req_sample_in;
         busy_in   = 1'b1;
         step_in   = STEP_RHO_DECAY;
      end
   end

   // Control, configuration and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_RHO_DECAY;
         rsp_valid_ff <= 1'b0;
         lambda_ff    <= anf_lms_pkg::LAMBDA_RESET;
         one_minus_ff <= anf_lms_pkg::ONE_MINUS_RESET;
         rho_final_ff <= anf_lms_pkg::RHO_FINAL_RESET;
         step_size_ff <= anf_lms_pkg::STEP_RESET;
         pole_ff      <= anf_lms_pkg::RHO_START_RESET;
         coef_ff      <= '0;
         prev_ff      <= '0;
         older_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         lambda_ff    <= lambda_in;
         one_minus_ff <= one_minus_in;
         rho_final_ff <= rho_final_in;
         step_size_ff <= step_size_in;
         pole_ff      <= pole_in;
         coef_ff      <= coef_in;
         prev_ff      <= prev_in;
         older_ff     <= older_in;
      end
   end

   // Working registers and output payload
   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      decay_ff      <= decay_in;
      partial_ff    <= partial_in;
      rho_sq_ff     <= rho_sq_in;
      rho_coef_ff   <= rho_coef_in;
      older_term_ff <= older_term_in;
      state_ff      <= state_in;
      error_ff      <= error_in;
      rsp_error_ff  <= rsp_error_in;
   end

endmodule

`default_nettype wire

/* tb/adaptive_notch_filter_lms_tb.sv */
// Self-checking testbench for adaptive_notch_filter_lms: sample, error and register channels.
// Depends on anf_lms_pkg and the RTL of the filter; a local fixed-point predictor
// computes each expected error beat.
`default_nettype none

module adaptive_notch_filter_lms_tb;

   // Predictor constants, kept apart from the package so the check stays independent
   localparam longint ROUND_BIAS   = 'h4000;
   localparam longint COEF_CEIL    = 32767;
   localparam longint COEF_FLOOR   = -32767;
   localparam longint ERROR_SCALE  = 16;
   localparam int     DRAIN_CYCLES = 12;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {SHAPE_TONE, SHAPE_SQUARE, SHAPE_NOISE, SHAPE_QUIET, SHAPE_RAIL} shape_type;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_sample_in = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic signed [20:0] rsp_error_out;
   logic               csr_valid     = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index     = '0;
   logic [15:0]        csr_data      = '0;

   // Predictor copy of the registers and the filter state
   longint cfg_lambda, cfg_one_minus, cfg_rho_final, cfg_step, cfg_rho_start;
   longint radius_q16, coef_q15, state_prev, state_old;

   logic signed [20:0] expected_errors [$];
   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;

   adaptive_notch_filter_lms dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_error_out (rsp_error_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #2 clock = ~clock;

   // Receiver: stall at random according to the current idle mode.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Error beat checker: compare each accepted beat against the oldest prediction.
   always @(posedge clock) begin : check_errors
      logic signed [20:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_errors.size() == 0) begin
            $display("%0t error_out beat with nothing pending: expected none actual %0d",
                     $time, rsp_error_out);
            mismatch_count++;
         end else begin
            want = expected_errors.pop_front();
            if (rsp_error_out !== want) begin
               $display("%0t error_out mismatch: expected %0d actual %0d",
                        $time, want, rsp_error_out);
               mismatch_count++;
            end
         end
      end
   end

   // Reinterpret the low 16 bits as a signed value.
   function automatic longint wrap_s16(input longint v);
      logic signed [15:0] w;
      w = v[15:0];
      return longint'(w);
   endfunction

   // Advance the predicted filter by one sample and return the notch error.
   task automatic predict_notch_error(input logic signed [15:0] smp,
                                      output logic signed [20:0] err);
      longint y, a, s1, s2, r2, p, q, t, s, e, g, na;
      y  = longint'(smp);
      a  = coef_q15;
      s1 = state_prev;
      s2 = state_old;

      // Radius relaxes toward its final value; the sum wraps at 16 bits.
      radius_q16 = (((cfg_lambda * radius_q16) >>> 15)
                  + ((cfg_one_minus * cfg_rho_final) >>> 15)) & 'hFFFF;

      r2 = (radius_q16 * radius_q16) >>> 16;
      p  = (radius_q16 * a + ROUND_BIAS) >>> 16;
      p  = (p * s1) >>> 15;
      q  = (-(a * s1) + ROUND_BIAS) >>> 15;
      t  = (r2 * s2) >>> 16;

      s = wrap_s16(y + p - t);
      e = (wrap_s16(s2 + q) + s) * ERROR_SCALE;

      // LMS step: the coefficient wraps first, then only the most negative code clamps.
      g  = (cfg_step * e * 2) >>> 15;
      g  = (g * s1) >>> 9;
      na = wrap_s16(a + g);
      if (na < COEF_FLOOR) na = COEF_FLOOR;
      if (na > COEF_CEIL)  na = COEF_CEIL;
      coef_q15 = na;

      state_old  = state_prev;
      state_prev = s;
      err = e[20:0];
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;  stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 62; stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;  stall_pct = 62;
         end
         default: begin
            send_idle_pct = 17; stall_pct = 17;
         end
      endcase
   endtask

   // Send one sample beat. Valid stays high on return so back-to-back beats
   // never lower and raise it in the same step; the caller drops it.
   task automatic send_sample(input logic signed [15:0] smp);
      logic signed [20:0] err;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_sample_in <= smp;
      do @(posedge clock); while (!req_ready);
      predict_notch_error(smp, err);
      expected_errors.push_back(err);
   endtask

   // Drop valid, then hold until every pending error beat has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_errors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write beat; csr_valid stays high for the caller to drop.
   task automatic write_csr(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         anf_lms_pkg::CSR_LAMBDA:    cfg_lambda    = data & 'h7FFF;
         anf_lms_pkg::CSR_ONE_MINUS: cfg_one_minus = data & 'h7FFF;
         anf_lms_pkg::CSR_RHO_FINAL: cfg_rho_final = data;
         anf_lms_pkg::CSR_STEP_SIZE: cfg_step      = data & 'h7FFF;
         anf_lms_pkg::CSR_RHO_START: cfg_rho_start = data;
         default: ;     // unknown index: no register changes
      endcase
   endtask

   // Write all five registers while the filter is idle.
   task automatic apply_settings(input logic [15:0] lambda, input logic [15:0] one_minus,
                                 input logic [15:0] rho_final, input logic [15:0] step,
                                 input logic [15:0] rho_start);
      wait_for_drain();
      write_csr(anf_lms_pkg::CSR_LAMBDA,    lambda);
      write_csr(anf_lms_pkg::CSR_ONE_MINUS, one_minus);
      write_csr(anf_lms_pkg::CSR_RHO_FINAL, rho_final);
      write_csr(anf_lms_pkg::CSR_STEP_SIZE, step);
      write_csr(anf_lms_pkg::CSR_RHO_START, rho_start);
      csr_valid <= 1'b0;
   endtask

   // Default registers: rails, zero, single-LSB values and alternating bit patterns.
   task automatic test_default_extremes();
      logic signed [15:0] pat [0:10] = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001,
                                         16'sh0001, 16'sh7FFF, 16'sh7FFF, -16'sh8000,
                                         16'sh5555, -16'sh5556, 16'sh0000};
      set_idle(IDLE_NONE);
      foreach (pat[i]) send_sample(pat[i]);
   endtask

   // Overwide data drops its top bit; writes to unused indexes change nothing.
   task automatic test_csr_masking();
      wait_for_drain();
      write_csr(anf_lms_pkg::CSR_LAMBDA,    16'hFFFF);
      write_csr(anf_lms_pkg::CSR_ONE_MINUS, 16'h8000);
      write_csr(anf_lms_pkg::CSR_STEP_SIZE, 16'h8123);
      for (int j = 1; j <= 3; j++) write_csr(3'(anf_lms_pkg::CSR_RHO_START + j), 16'hFFFF);
      write_csr(anf_lms_pkg::CSR_RHO_START, 16'h0000);
      csr_valid <= 1'b0;
      send_sample(16'sh4000);
      send_sample(-16'sh4000);
      send_sample(16'sh1234);
   endtask

   // Both radius terms near full scale so the update sum wraps past 16 bits.
   task automatic test_radius_wrap();
      apply_settings(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'd328, 16'hFFFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(16'sh0100);
   endtask

   // Maximum step on rail samples: drive the coefficient to wrap and clamp.
   task automatic test_coef_saturation();
      apply_settings(16'd29491, 16'd3276, 16'hFFFF, 16'h7FFF, 16'd32768);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(-16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh0000);
   endtask

   // Random traffic: mostly periodic segments (what the filter is built to track),
   // with noise, quiet stretches and rail hits mixed in. Shape changes per segment.
   task automatic run_random_items(input int count);
      shape_type shape;
      int left, pos, period, half, amp, ph, roll, v;
      left = 0;
      pos  = 0;
      for (int n = 0; n < count; n++) begin
         if (left == 0) begin
            left   = $urandom_range(64, 16);
            pos    = 0;
            period = $urandom_range(40, 4);
            amp    = $urandom_range(32767, 1) >> $urandom_range(12, 0);
            if (amp == 0) amp = 1;
            roll   = $urandom_range(99);
            shape  = roll < 30 ? SHAPE_TONE  : roll < 55 ? SHAPE_SQUARE :
                     roll < 75 ? SHAPE_NOISE : roll < 90 ? SHAPE_QUIET  : SHAPE_RAIL;
         end
         half = period / 2;
         ph   = pos % period;
         case (shape)
            SHAPE_TONE: begin
               v = (ph < half) ? -amp + (2 * amp * ph) / half
                               : amp - (2 * amp * (ph - half)) / (period - half);
               v = v + $urandom_range(15) - 8;
            end
            SHAPE_SQUARE: v = ((pos / half) % 2) ? amp : -amp;
            SHAPE_NOISE:  v = $urandom_range(65535);
            SHAPE_QUIET:  v = $urandom_range(511) - 256;
            default: begin
               case ($urandom_range(3))
                  0:       v = 32767;
                  1:       v = -32768;
                  2:       v = 0;
                  default: v = -1;
               endcase
            end
         endcase
         send_sample(v[15:0]);
         pos++;
         left--;
      end
   endtask

   // Sweep register settings, extremes included; each runs every idle mode.
   task automatic test_random_traffic();
      int lam;
      for (int k = 0; k < 6; k++) begin
         lam = $urandom_range(32767, 24000);
         case (k)
            0: apply_settings(16'd29491, 16'd3276, 16'd62259, 16'd328, 16'd32768);
            1: apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
            2: apply_settings(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
            3, 4: apply_settings(16'(lam), 16'(32768 - lam), 16'($urandom_range(65535, 50000)),
                                 16'($urandom_range(1023)), 16'($urandom_range(65535)));
            default: apply_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                    16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                    16'($urandom_range(65535)));
         endcase
         for (int m = 0; m < 4; m++) begin
            set_idle(idle_mode_type'(m));
            run_random_items(62);
         end
      end
      set_idle(IDLE_NONE);
   endtask

   initial begin
      // Reset loads the register defaults and the start radius.
      cfg_lambda    = anf_lms_pkg::LAMBDA_RESET;
      cfg_one_minus = anf_lms_pkg::ONE_MINUS_RESET;
      cfg_rho_final = anf_lms_pkg::RHO_FINAL_RESET;
      cfg_step      = anf_lms_pkg::STEP_RESET;
      cfg_rho_start = anf_lms_pkg::RHO_START_RESET;
      radius_q16    = anf_lms_pkg::RHO_START_RESET;
      coef_q15      = 0;
      state_prev    = 0;
      state_old     = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_default_extremes();
      test_csr_masking();
      test_radius_wrap();
      test_coef_saturation();
      test_random_traffic();

      wait_for_drain();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
rtl/anf_lms_pkg.sv
rtl/anf_lms_mul.sv
rtl/adaptive_notch_filter_lms.sv
tb/adaptive_notch_filter_lms_tb.sv
